FILE: hdl/ast_pkg.sv
// Shared types and constants for the association table.
// Depends on nothing; every other file of the block depends on it.
package ast_pkg;

	localparam int KEY_W   = 32;
	localparam int SID_W   = 16;
	localparam int RSSI_W  = 8;
	localparam int TS_W    = 64;
	localparam int LIMIT_W = 5;
	localparam int SLOT_W  = 5;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_LOOKUP = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BAD_ID = 2'd1,
		ST_FULL   = 2'd2,
		ST_MISS   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0]         long_id;
		logic [SID_W-1:0]         short_id;
		logic signed [RSSI_W-1:0] rssi;
		logic [TS_W-1:0]          last_seen;
	} entry_t;

endpackage

FILE: hdl/ast_if.sv
// Request and response channel interfaces of the association table.
// Depends on ast_pkg for the field widths.
interface ast_req_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        kind;
	logic [ast_pkg::KEY_W-1:0]         long_id;
	logic [ast_pkg::SID_W-1:0]         short_id;
	logic signed [ast_pkg::RSSI_W-1:0] rssi;
	logic [ast_pkg::TS_W-1:0]          timestamp;

	modport source (output valid, kind, long_id, short_id, rssi, timestamp, input ready);
	modport sink   (input valid, kind, long_id, short_id, rssi, timestamp, output ready);
endinterface

interface ast_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        status;
	logic [ast_pkg::SLOT_W-1:0]        slot_index;
	logic [ast_pkg::SLOT_W-1:0]        entry_count;
	logic [ast_pkg::SID_W-1:0]         stored_short_id;
	logic signed [ast_pkg::RSSI_W-1:0] stored_rssi;
	logic [ast_pkg::TS_W-1:0]          stored_timestamp;

	modport source (output valid, status, slot_index, entry_count, stored_short_id,
		stored_rssi, stored_timestamp, input ready);
	modport sink   (input valid, status, slot_index, entry_count, stored_short_id,
		stored_rssi, stored_timestamp, output ready);
endinterface

FILE: hdl/ast_entry_ram.sv
// Entry memory of the association table: one write and one read port,
// read data registered. Depends on ast_pkg for the entry type.
module ast_entry_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  ast_pkg::entry_t   wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output ast_pkg::entry_t   rdata
);
	import ast_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/association_table_core.sv
// Association table: a keyed table of radio devices held in an entry RAM with
// one used flag per slot in flip-flops. Depends on ast_pkg, ast_if and ast_entry_ram.
//
// One request word is taken when the block is idle. The block then scans the
// entry RAM one slot per cycle over the active limit L (max_entries, 0 read as
// 1, capped at TABLE_DEPTH), comparing each stored long id in the cycle after its
// read, counting used slots and noting the first match and the first free slot.
// A final step applies the update and loads the response register, which
// holds the result until it is taken; the next request is accepted meanwhile
// and finishes once the response register is free. Clear-all drops every
// used flag at once. The max_entries register (reset 16) must be written
// only while no request is in flight.
module association_table_core #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ast_pkg::LIMIT_W-1:0]  cfg_wdata,
	ast_req_if.sink                      req,
	ast_rsp_if.source                    rsp
);
	import ast_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int LW    = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

	// control state
	state_t                  state_q;
	logic [LIMIT_W-1:0]      max_q;
	logic [TABLE_DEPTH-1:0]  used_q;
	logic [CNT_W-1:0]        rd_idx_q;
	logic                    cmp_vld_s1;
	logic                    hit_q;
	logic                    free_q;
	logic                    rsp_valid_q;

	// request and scan payload
	logic [1:0]              kind_q;
	logic [KEY_W-1:0]        key_q;
	logic [SID_W-1:0]        sid_q;
	logic signed [RSSI_W-1:0] rssi_q;
	logic [TS_W-1:0]         ts_q;
	logic [CNT_W-1:0]        lim_q;
	logic [IDX_W-1:0]        cmp_idx_s1;
	logic [IDX_W-1:0]        hit_idx_q;
	logic [IDX_W-1:0]        free_idx_q;
	logic [CNT_W-1:0]        cnt_q;
	entry_t                  hit_data_q;

	// response register payload
	logic [1:0]              rsp_status_q;
	logic [SLOT_W-1:0]       rsp_slot_q;
	logic [SLOT_W-1:0]       rsp_cnt_q;
	logic [SID_W-1:0]        rsp_sid_q;
	logic signed [RSSI_W-1:0] rsp_rssi_q;
	logic [TS_W-1:0]         rsp_ts_q;

	logic                    req_fire;
	logic                    rd_en;
	logic                    fin_go;
	logic [LW-1:0]           max_ext;
	logic [LW-1:0]           lim_ext;
	entry_t                  rd_data;
	entry_t                  wr_data;
	logic                    slot_used;
	logic                    slot_match;
	logic                    scan_last;

	// finish-cycle decision
	logic [1:0]              res_status;
	logic [CNT_W-1:0]        res_slot;
	logic [CNT_W-1:0]        res_cnt;
	logic                    res_data;
	logic                    wr_en;
	logic [IDX_W-1:0]        wr_idx;
	logic                    clr_one;
	logic                    clr_all;
	logic [LW-1:0]           slot_ext;
	logic [LW-1:0]           cnt_ext;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;

	// Fold the limit register into 1 .. TABLE_DEPTH.
	assign max_ext = LW'(max_q);
	always_comb begin
		if (max_q == '0) begin
			lim_ext = LW'(1);
		end else if (max_ext > LW'(TABLE_DEPTH)) begin
			lim_ext = LW'(TABLE_DEPTH);
		end else begin
			lim_ext = max_ext;
		end
	end

	// Issue one read per cycle until the limit is reached.
	assign rd_en = (state_q == S_SCAN) && (rd_idx_q < lim_q);

	assign wr_data.long_id   = key_q;
	assign wr_data.short_id  = sid_q;
	assign wr_data.rssi      = rssi_q;
	assign wr_data.last_seen = ts_q;

	ast_entry_ram #(
		.DEPTH (TABLE_DEPTH),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_idx),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (rd_data)
	);

	// Compare stage: read data of slot cmp_idx_s1 is valid here.
	assign slot_used  = used_q[cmp_idx_s1];
	assign slot_match = slot_used && (rd_data.long_id == key_q);
	assign scan_last  = cmp_vld_s1 && ((CNT_W'(cmp_idx_s1) + CNT_W'(1)) == lim_q);

	assign fin_go = (state_q == S_FINISH) && (!rsp_valid_q || rsp.ready);

	// Work out the result and the table update from the scan summary.
	always_comb begin
		res_status = ST_OK;
		res_slot   = '0;
		res_cnt    = cnt_q;
		res_data   = 1'b0;
		wr_en      = 1'b0;
		wr_idx     = hit_idx_q;
		clr_one    = 1'b0;
		clr_all    = 1'b0;
		if (kind_q == KIND_CLEAR) begin
			res_cnt = '0;
			clr_all = fin_go;
		end else if (key_q == '0) begin
			res_status = ST_BAD_ID;
		end else begin
			case (kind_q)
				KIND_ADD: begin
					if (hit_q) begin
						res_slot = CNT_W'(hit_idx_q) + CNT_W'(1);
						wr_en    = fin_go;
					end else if (free_q) begin
						wr_idx   = free_idx_q;
						res_slot = CNT_W'(free_idx_q) + CNT_W'(1);
						res_cnt  = cnt_q + CNT_W'(1);
						wr_en    = fin_go;
					end else begin
						res_status = ST_FULL;
					end
				end
				KIND_LOOKUP: begin
					if (hit_q) begin
						res_slot = CNT_W'(hit_idx_q) + CNT_W'(1);
						res_data = 1'b1;
					end else begin
						res_status = ST_MISS;
					end
				end
				KIND_REMOVE: begin
					if (hit_q) begin
						res_slot = CNT_W'(hit_idx_q) + CNT_W'(1);
						res_cnt  = cnt_q - CNT_W'(1);
						clr_one  = fin_go;
					end else begin
						res_status = ST_MISS;
					end
				end
				default: begin
					res_status = ST_OK;
				end
			endcase
		end
	end

	assign slot_ext = LW'(res_slot);
	assign cnt_ext  = LW'(res_cnt);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			max_q       <= LIMIT_RESET;
			used_q      <= '0;
			rd_idx_q    <= '0;
			cmp_vld_s1  <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			cmp_vld_s1 <= rd_en;
			if (rd_en) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						rd_idx_q <= '0;
						hit_q    <= 1'b0;
						free_q   <= 1'b0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (cmp_vld_s1) begin
						if (slot_match) begin
							hit_q <= 1'b1;
						end
						if (!slot_used) begin
							free_q <= 1'b1;
						end
					end
					if (scan_last) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// Apply the update on the finish cycle.
			if (clr_all) begin
				used_q <= '0;
			end else if (wr_en) begin
				used_q[wr_idx] <= 1'b1;
			end else if (clr_one) begin
				used_q[hit_idx_q] <= 1'b0;
			end
			if (fin_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: request capture, scan summary and response.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			kind_q <= req.kind;
			key_q  <= req.long_id;
			sid_q  <= req.short_id;
			rssi_q <= req.rssi;
			ts_q   <= req.timestamp;
			lim_q  <= lim_ext[CNT_W-1:0];
			cnt_q  <= '0;
		end
		cmp_idx_s1 <= rd_idx_q[IDX_W-1:0];
		if (state_q == S_SCAN && cmp_vld_s1) begin
			if (slot_used) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			// keep only the first match and the first free slot
			if (slot_match && !hit_q) begin
				hit_idx_q  <= cmp_idx_s1;
				hit_data_q <= rd_data;
			end
			if (!slot_used && !free_q) begin
				free_idx_q <= cmp_idx_s1;
			end
		end
		if (fin_go) begin
			rsp_status_q <= res_status;
			rsp_slot_q   <= slot_ext[SLOT_W-1:0];
			rsp_cnt_q    <= cnt_ext[SLOT_W-1:0];
			rsp_sid_q    <= res_data ? hit_data_q.short_id : '0;
			rsp_rssi_q   <= res_data ? hit_data_q.rssi : '0;
			rsp_ts_q     <= res_data ? hit_data_q.last_seen : '0;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.status           = rsp_status_q;
	assign rsp.slot_index       = rsp_slot_q;
	assign rsp.entry_count      = rsp_cnt_q;
	assign rsp.stored_short_id  = rsp_sid_q;
	assign rsp.stored_rssi      = rsp_rssi_q;
	assign rsp.stored_timestamp = rsp_ts_q;

endmodule

FILE: hdl/ast_checker.sv
// Port-level checks for association_table_core, attached by the bind below.
// Depends on ast_pkg for the status codes.
module ast_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [1:0]                   rsp_status,
	input logic [ast_pkg::SLOT_W-1:0]   rsp_slot_index,
	input logic [ast_pkg::SID_W-1:0]    rsp_sid,
	input logic [ast_pkg::RSSI_W-1:0]   rsp_rssi,
	input logic [ast_pkg::TS_W-1:0]     rsp_ts
);
	import ast_pkg::*;

	logic [1:0] pend_q;

	// track words accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_slot_index) && $stable(rsp_ts))
		else $error("response word changed while stalled");

	a_fail_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |-> rsp_slot_index == '0
			&& rsp_sid == '0 && rsp_rssi == '0 && rsp_ts == '0)
		else $error("failed request reports a slot or stored data");

	a_rsp_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("response without an outstanding request");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 2'd2 |-> !req_ready)
		else $error("request accepted with two words outstanding");

endmodule

bind association_table_core ast_checker u_ast_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_slot_index (rsp.slot_index),
	.rsp_sid        (rsp.stored_short_id),
	.rsp_rssi       (rsp.stored_rssi),
	.rsp_ts         (rsp.stored_timestamp)
);
